/* rtl/rrts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Slot table types, command and status codes, and small slot helpers.
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int THREAD_SLOTS = 16;
   localparam int SLOT_W       = $clog2(THREAD_SLOTS);
   localparam int CNT_W        = $clog2(THREAD_SLOTS + 1);

   typedef logic [SLOT_W-1:0] slot_idx_type;
   typedef logic [CNT_W-1:0]  slot_cnt_type;

   typedef enum logic [1:0] {
      CMD_CREATE = 2'd0,
      CMD_EXIT   = 2'd1,
      CMD_JOIN   = 2'd2,
      CMD_YIELD  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_FULL          = 2'd1,
      STATUS_TARGET_DEAD   = 2'd2,
      STATUS_NONE_RUNNABLE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_DEAD     = 2'd0,
      ST_RUNNABLE = 2'd1,
      ST_RUNNING  = 2'd2,
      ST_BLOCKED  = 2'd3
   } slot_state_type;

   typedef struct packed {
      cmd_type    command;
      logic [3:0] target_thread;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [3:0] new_thread;
      logic [3:0] now_running;
   } rsp_type;

   typedef struct packed {
      slot_state_type st;
      logic           jvalid;
      slot_idx_type   jslot;
   } slot_rec_type;

   typedef struct packed {
      logic         en;
      slot_idx_type addr;
      slot_rec_type data;
   } tbl_wr_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } done_type;

   function automatic slot_rec_type reset_rec(input slot_idx_type idx);
      slot_rec_type r;
      r.st     = (idx == '0) ? ST_RUNNING : ST_DEAD;
      r.jvalid = 1'b0;
      r.jslot  = '0;
      return r;
   endfunction

   function automatic slot_idx_type next_slot(input slot_idx_type idx);
      slot_idx_type n;
      n = (idx == slot_idx_type'(THREAD_SLOTS - 1)) ? '0 : idx + slot_idx_type'(1);
      return n;
   endfunction

   function automatic logic [3:0] to_field(input slot_idx_type idx);
      logic [SLOT_W+3:0] w;
      w = {4'b0000, idx};
      return w[3:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/rrts_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Slot table
// One-read, one-write slot record memory with registered read data. Entries
// not yet written read as their reset record.
// ----------------------------------------------------------------------------
module rrts_table (
   input  logic                  clock,
   input  logic                  reset,
   input  rrts_pkg::slot_idx_type rd_addr,
   output rrts_pkg::slot_rec_type rd_rec,
   input  rrts_pkg::tbl_wr_type   wr
);
   import rrts_pkg::*;

   slot_rec_type              slot_mem_ff [THREAD_SLOTS];
   logic [THREAD_SLOTS-1:0]   written_ff;
   slot_rec_type              rd_data_ff;
   logic                      rd_written_ff;
   slot_idx_type              rd_addr_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         slot_mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff    <= slot_mem_ff[rd_addr];
      rd_written_ff <= written_ff[rd_addr];
      rd_addr_ff    <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr.en) begin
         written_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_rec = rd_written_ff ? rd_data_ff : reset_rec(rd_addr_ff);

endmodule
`default_nettype wire

/* rtl/rrts_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Steps one request through reads, a round-robin scan and record updates of
// the slot table, sharing one compare and increment unit for the scan.
// ----------------------------------------------------------------------------
module rrts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rrts_pkg::req_type      req_payload,
   input  logic                   out_free,
   output rrts_pkg::done_type     done,
   output rrts_pkg::slot_idx_type rd_addr,
   input  rrts_pkg::slot_rec_type rd_rec,
   output rrts_pkg::tbl_wr_type   wr
);
   import rrts_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_CUR_RD  = 14'b00000000000010,
      S_CUR_CHK = 14'b00000000000100,
      S_J_RD    = 14'b00000000001000,
      S_J_CHK   = 14'b00000000010000,
      S_TGT_RD  = 14'b00000000100000,
      S_TGT_CHK = 14'b00000001000000,
      S_SCAN    = 14'b00000010000000,
      S_CUR_WR  = 14'b00000100000000,
      S_NEW_WR  = 14'b00001000000000,
      S_TGT_RD2 = 14'b00010000000000,
      S_TGT_WR  = 14'b00100000000000,
      S_NEXT_RD = 14'b01000000000000,
      S_DONE    = 14'b10000000000000
   } fsm_type;

   fsm_type        state_ff,     state_in;
   slot_idx_type   running_ff,   running_in;
   cmd_type        cmd_ff,       cmd_in;
   slot_idx_type   tgt_ff,       tgt_in;
   logic           tgt_live_ff,  tgt_live_in;
   logic           active_ff,    active_in;
   slot_rec_type   cur_rec_ff,   cur_rec_in;
   slot_idx_type   joiner_ff,    joiner_in;
   status_type     status_ff,    status_in;
   slot_idx_type   created_ff,   created_in;
   slot_idx_type   next_ff,      next_in;
   slot_idx_type   scan_addr_ff, scan_addr_in;
   slot_cnt_type   left_ff,      left_in;
   logic           pend_ff,      pend_in;
   slot_idx_type   pend_addr_ff, pend_addr_in;

   logic [SLOT_W+3:0] tgt_ext;
   logic              cur_active;
   logic              scan_hit;
   logic              scan_miss;
   logic              issue;

   assign tgt_ext    = {{SLOT_W{1'b0}}, req_payload.target_thread};
   assign cur_active = (rd_rec.st == ST_RUNNING);
   assign issue      = (left_ff != '0);
   assign scan_hit   = pend_ff && ((cmd_ff == CMD_CREATE) ? (rd_rec.st == ST_DEAD)
                                                          : (rd_rec.st == ST_RUNNABLE));
   assign scan_miss  = !scan_hit && !issue;
   assign req_stall  = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      cmd_in       = cmd_ff;
      tgt_in       = tgt_ff;
      tgt_live_in  = tgt_live_ff;
      active_in    = active_ff;
      cur_rec_in   = cur_rec_ff;
      joiner_in    = joiner_ff;
      status_in    = status_ff;
      created_in   = created_ff;
      next_in      = next_ff;
      scan_addr_in = (cmd_ff == CMD_CREATE) ? '0 : next_slot(running_ff);
      left_in      = (cmd_ff == CMD_CREATE) ? slot_cnt_type'(THREAD_SLOTS)
                                            : slot_cnt_type'(THREAD_SLOTS - 1);
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      rd_addr      = running_ff;
      wr           = '0;
      done.valid   = 1'b0;
      done.rsp.status      = status_ff;
      done.rsp.new_thread  = to_field(created_ff);
      done.rsp.now_running = to_field(running_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_payload.command;
               tgt_in      = tgt_ext[SLOT_W-1:0];
               tgt_live_in = (tgt_ext < (SLOT_W + 4)'(THREAD_SLOTS));
               status_in   = STATUS_OK;
               created_in  = '0;
               state_in    = S_CUR_RD;
            end
         end
         S_CUR_RD: begin
            rd_addr  = running_ff;
            state_in = S_CUR_CHK;
         end
         S_CUR_CHK: begin
            active_in  = cur_active;
            cur_rec_in = rd_rec;
            joiner_in  = rd_rec.jslot;
            unique case (cmd_ff)
               CMD_CREATE, CMD_YIELD: begin
                  state_in = S_SCAN;
               end
               CMD_EXIT: begin
                  if (cur_active) begin
                     wr.en      = 1'b1;
                     wr.addr    = running_ff;
                     wr.data.st = ST_DEAD;
                  end
                  state_in = (cur_active && rd_rec.jvalid) ? S_J_RD : S_SCAN;
               end
               CMD_JOIN: begin
                  if (!tgt_live_ff) begin
                     status_in = STATUS_TARGET_DEAD;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_TGT_RD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_J_RD: begin
            rd_addr  = joiner_ff;
            state_in = S_J_CHK;
         end
         S_J_CHK: begin
            if (rd_rec.st == ST_BLOCKED) begin
               wr.en      = 1'b1;
               wr.addr    = joiner_ff;
               wr.data    = rd_rec;
               wr.data.st = ST_RUNNABLE;
            end
            state_in = S_SCAN;
         end
         S_TGT_RD: begin
            rd_addr  = tgt_ff;
            state_in = S_TGT_CHK;
         end
         S_TGT_CHK: begin
            if (rd_rec.st == ST_DEAD) begin
               status_in = STATUS_TARGET_DEAD;
               state_in  = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_addr      = scan_addr_ff;
            pend_in      = issue;
            pend_addr_in = scan_addr_ff;
            scan_addr_in = issue ? next_slot(scan_addr_ff) : scan_addr_ff;
            left_in      = issue ? left_ff - slot_cnt_type'(1) : left_ff;
            if (scan_hit) begin
               next_in = pend_addr_ff;
               unique case (cmd_ff)
                  CMD_CREATE: state_in = active_ff ? S_CUR_WR : S_NEW_WR;
                  CMD_EXIT:   state_in = S_NEXT_RD;
                  CMD_JOIN:   state_in = active_ff ? S_CUR_WR : S_TGT_RD2;
                  CMD_YIELD:  state_in = active_ff ? S_CUR_WR : S_NEXT_RD;
                  default:    state_in = S_IDLE;
               endcase
            end else if (scan_miss) begin
               status_in = (cmd_ff == CMD_CREATE) ? STATUS_FULL : STATUS_NONE_RUNNABLE;
               state_in  = S_DONE;
            end
         end
         S_CUR_WR: begin
            wr.en      = 1'b1;
            wr.addr    = running_ff;
            wr.data    = cur_rec_ff;
            wr.data.st = (cmd_ff == CMD_JOIN) ? ST_BLOCKED : ST_RUNNABLE;
            unique case (cmd_ff)
               CMD_CREATE: state_in = S_NEW_WR;
               CMD_JOIN:   state_in = S_TGT_RD2;
               default:    state_in = S_NEXT_RD;
            endcase
         end
         S_NEW_WR: begin
            wr.en      = 1'b1;
            wr.addr    = next_ff;
            wr.data.st = ST_RUNNING;
            running_in = next_ff;
            created_in = next_ff;
            state_in   = S_DONE;
         end
         S_TGT_RD2: begin
            rd_addr  = tgt_ff;
            state_in = S_TGT_WR;
         end
         S_TGT_WR: begin
            wr.en          = 1'b1;
            wr.addr        = tgt_ff;
            wr.data.st     = rd_rec.st;
            wr.data.jvalid = 1'b1;
            wr.data.jslot  = running_ff;
            state_in       = S_NEXT_RD;
         end
         S_NEXT_RD: begin
            rd_addr  = next_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            // the read of the chosen slot lands here: promote it, then report
            if (status_ff == STATUS_OK && cmd_ff != CMD_CREATE && running_ff != next_ff) begin
               wr.en      = 1'b1;
               wr.addr    = next_ff;
               wr.data    = rd_rec;
               wr.data.st = ST_RUNNING;
               running_in = next_ff;
               state_in   = S_DONE;
            end else if (out_free) begin
               done.valid = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         running_ff <= '0;
      end else begin
         state_ff   <= state_in;
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      tgt_ff       <= tgt_in;
      tgt_live_ff  <= tgt_live_in;
      active_ff    <= active_in;
      cur_rec_ff   <= cur_rec_in;
      joiner_ff    <= joiner_in;
      status_ff    <= status_in;
      created_ff   <= created_in;
      next_ff      <= next_in;
      scan_addr_ff <= scan_addr_in;
      left_ff      <= left_in;
      pend_ff      <= pend_in;
      pend_addr_ff <= pend_addr_in;
   end

endmodule
`default_nettype wire

/* rtl/round_robin_thread_scheduler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Thread slot table with create, exit, join and yield, one request at a time.
// ----------------------------------------------------------------------------
// A join on a dead target is the shortest request, and a join whose scan finds
// a runnable slot only at its last read is the longest. How long a request
// runs is set by the round-robin scan, which reads one slot record a cycle
// through the single read port of the slot table, plus the read-modify-write
// steps that update the affected slots. The block takes no new request while
// one is in progress, and takes the next one once it is back in its idle
// state; a finished response waits in the output register without holding
// up the acceptance of the next request.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rrts_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rrts_pkg::rsp_type rsp_payload
);
   import rrts_pkg::*;

   slot_idx_type rd_addr;
   slot_rec_type rd_rec;
   tbl_wr_type   wr;
   done_type     done;
   logic         out_free;

   logic         rsp_valid_ff;
   rsp_type      rsp_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   rrts_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_rec  (rd_rec),
      .wr      (wr)
   );

   rrts_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .out_free    (out_free),
      .done        (done),
      .rd_addr     (rd_addr),
      .rd_rec      (rd_rec),
      .wr          (wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_ff <= done.rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
